@@ rtl/gprr_pkg.sv @@
// Shared constants, types and stage records of the glyph row pixel renderer.
package gprr_pkg;

    // Glyph store geometry.
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COUNT = 95;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Largest effective screen dimension or pitch.
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int PROD_W  = COORD_W + DIM_W;

    // Fixed field widths.
    localparam int CFG_W      = 13;
    localparam int OFFSET_W   = 24;
    localparam int COLOR_W    = 32;
    localparam int ROW_PIXELS = 8;
    localparam int COL_W      = 3;

    // Character codes.
    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;
    localparam logic [7:0] SUBST_CODE = 8'd63;

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH     = 2'd2;

    // Draw item after the glyph fetch.
    typedef struct packed {
        logic signed [16:0]        y;
        logic signed [15:0]        px;
        logic [ROW_PIXELS-1:0]     bits;
        logic [COLOR_W-1:0]        fg;
        logic [COLOR_W-1:0]        bg;
        logic                      opaque;
    } fetch_t;

    // Draw item after clipping and address generation; bit c is column c.
    typedef struct packed {
        logic [OFFSET_W-1:0]       base;
        logic [ROW_PIXELS-1:0]     mask;
        logic [ROW_PIXELS-1:0]     on;
        logic [COLOR_W-1:0]        fg;
        logic [COLOR_W-1:0]        bg;
    } span_t;

endpackage

@@ rtl/glyph_row_pixel_renderer_unit.sv @@
// Top level of the glyph row pixel renderer: configuration registers and pipeline.
//
// This block turns glyph row draw transactions into framebuffer pixel writes for a
// 32-bit linear framebuffer, one write per cycle on the result channel while the
// receiver does not stall. A load transaction (op 0) stores one glyph row byte when
// its code is printable and produces no result. A draw transaction (op 1) reads one
// glyph row from the on-chip glyph store and produces one result for every pixel
// that is painted and lies inside the configured screen, leftmost pixel first, with
// last_write set on the final one; a draw that paints nothing produces no result at
// all. The result channel limits throughput: a draw occupies the expansion stage
// until the last of its pixel writes (at most eight) is issued, and the next draw
// follows with no gap. The pipeline has five register stages (glyph read, clip and
// multiply, base add, expansion, output), and the first pixel of a draw passes
// through all five in that order before it appears on the output. The glyph store
// is a 1520-entry memory with no reset: every glyph row must be loaded before it is
// drawn, and a draw of an unloaded row gives unspecified pixels.
// The user must write screen width, height and row pitch through the configuration
// port only while no transaction is in flight; the block itself does not enforce
// this. Values above 4096 act as 4096.
module glyph_row_pixel_renderer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [1:0]                      cfg_index,
    input  logic [12:0]                     cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [7:0]                      char_code,
    input  logic [3:0]                      glyph_row,
    input  logic [7:0]                      glyph_bits,
    input  logic signed [15:0]              pos_x,
    input  logic signed [15:0]              pos_y,
    input  logic [31:0]                     fg_color,
    input  logic [31:0]                     bg_color,
    input  logic                            opaque,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [23:0]                     pixel_offset,
    output logic [31:0]                     pixel_value,
    output logic                            last_write
);

    // Configuration registers hold the saturated, effective values.
    logic [gprr_pkg::DIM_W-1:0]   width_reg;
    logic [gprr_pkg::DIM_W-1:0]   height_reg;
    logic [gprr_pkg::DIM_W-1:0]   pitch_reg;
    logic [gprr_pkg::DIM_W-1:0]   cfg_sat;

    logic                         s1_valid;
    gprr_pkg::fetch_t             s1_data;
    logic                         s1_ready;
    logic                         s3_valid;
    gprr_pkg::span_t              s3_data;
    logic                         s3_ready;

    assign cfg_sat = (32'(cfg_wdata) > 32'(gprr_pkg::MAX_DIM))
                   ? gprr_pkg::DIM_W'(gprr_pkg::MAX_DIM)
                   : gprr_pkg::DIM_W'(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            pitch_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                gprr_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_sat;
                gprr_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_sat;
                gprr_pkg::REG_ROW_PITCH:     pitch_reg  <= cfg_sat;
                default:                     ;
            endcase
        end
    end

    // Stage 1: code mapping and glyph store access.
    gprr_glyph_fetch u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .glyph_row  (glyph_row),
        .glyph_bits (glyph_bits),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .fg_color   (fg_color),
        .bg_color   (bg_color),
        .opaque     (opaque),
        .s1_valid   (s1_valid),
        .s1_data    (s1_data),
        .s1_ready   (s1_ready)
    );

    // Stages 2 and 3: clipping mask, row times pitch, base offset.
    gprr_clip u_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .width      (width_reg),
        .height     (height_reg),
        .pitch      (pitch_reg),
        .up_valid   (s1_valid),
        .up_data    (s1_data),
        .up_ready   (s1_ready),
        .s3_valid   (s3_valid),
        .s3_data    (s3_data),
        .down_ready (s3_ready)
    );

    // Stage 4 and output register: one pixel write per cycle while the output is not stalled.
    gprr_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (s3_valid),
        .up_data      (s3_data),
        .up_ready     (s3_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_offset (pixel_offset),
        .pixel_value  (pixel_value),
        .last_write   (last_write)
    );

    // The input side only stalls when the first stage holds a draw.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid)
        else $error("input stalled with an empty fetch stage");

    // A load transaction never enters the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == gprr_pkg::OP_LOAD) |=> !s1_valid)
        else $error("load transaction entered the draw pipeline");

    // A span that the expansion stage cannot take yet keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && !s3_ready) |=> (s3_valid && $stable(s3_data)))
        else $error("span changed while waiting for the expansion stage");

endmodule

@@ rtl/gprr_glyph_fetch.sv @@
// Input stage: glyph store memory, code substitution and glyph row read.
module gprr_glyph_fetch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [7:0]                    char_code,
    input  logic [3:0]                    glyph_row,
    input  logic [7:0]                    glyph_bits,
    input  logic signed [15:0]            pos_x,
    input  logic signed [15:0]            pos_y,
    input  logic [31:0]                   fg_color,
    input  logic [31:0]                   bg_color,
    input  logic                          opaque,
    output logic                          s1_valid,
    output gprr_pkg::fetch_t              s1_data,
    input  logic                          s1_ready
);

    logic [7:0]                    glyph_mem [gprr_pkg::STORE_DEPTH];
    logic [7:0]                    rdata_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          glyph_ok_reg;
    logic signed [16:0]            y_reg;
    logic signed [15:0]            px_reg;
    logic [31:0]                   fg_reg;
    logic [31:0]                   bg_reg;
    logic                          opaque_reg;

    logic                          stage_ready;
    logic                          accept;
    logic                          row_ok;
    logic                          code_ok;
    logic [7:0]                    sel_code;
    logic [7:0]                    gidx;
    logic                          glyph_ok;
    logic [gprr_pkg::ADDR_W-1:0]   addr;
    logic                          mem_we;
    logic                          mem_re;
    logic signed [16:0]            y_next;

    assign stage_ready = !s1_valid_reg || s1_ready;
    assign in_stall    = !stage_ready;
    assign accept      = in_valid && stage_ready;

    assign row_ok   = 32'(glyph_row) < 32'(gprr_pkg::GLYPH_ROWS);
    assign code_ok  = (char_code >= gprr_pkg::FIRST_CODE) && (char_code <= gprr_pkg::LAST_CODE);
    assign sel_code = (op == gprr_pkg::OP_LOAD || code_ok) ? char_code : gprr_pkg::SUBST_CODE;
    assign gidx     = sel_code - gprr_pkg::FIRST_CODE;
    assign glyph_ok = 32'(gidx) < 32'(gprr_pkg::GLYPH_COUNT);
    assign addr     = gprr_pkg::ADDR_W'(32'(gidx) * 32'(gprr_pkg::GLYPH_ROWS) + 32'(glyph_row));

    assign mem_we = accept && (op == gprr_pkg::OP_LOAD) && code_ok && glyph_ok && row_ok;
    assign mem_re = accept && (op == gprr_pkg::OP_DRAW) && row_ok;

    assign y_next = {pos_y[15], pos_y} + {13'd0, glyph_row};

    assign s1_valid_next = stage_ready ? mem_re : s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            glyph_mem[addr] <= glyph_bits;
        end
        if (mem_re)
        begin
            rdata_reg    <= glyph_mem[addr];
            glyph_ok_reg <= glyph_ok;
            y_reg        <= y_next;
            px_reg       <= pos_x;
            fg_reg       <= fg_color;
            bg_reg       <= bg_color;
            opaque_reg   <= opaque;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign s1_valid       = s1_valid_reg;
    assign s1_data.y      = y_reg;
    assign s1_data.px     = px_reg;
    assign s1_data.bits   = glyph_ok_reg ? rdata_reg : 8'd0;
    assign s1_data.fg     = fg_reg;
    assign s1_data.bg     = bg_reg;
    assign s1_data.opaque = opaque_reg;

endmodule

@@ rtl/gprr_clip.sv @@
// Clip and address stages: visibility mask, row times pitch, base offset.
module gprr_clip (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gprr_pkg::DIM_W-1:0]    width,
    input  logic [gprr_pkg::DIM_W-1:0]    height,
    input  logic [gprr_pkg::DIM_W-1:0]    pitch,
    input  logic                          up_valid,
    input  gprr_pkg::fetch_t              up_data,
    output logic                          up_ready,
    output logic                          s3_valid,
    output gprr_pkg::span_t               s3_data,
    input  logic                          down_ready
);

    // Second stage: mask and product.
    logic                                 v2_reg;
    logic                                 v2_next;
    logic [gprr_pkg::PROD_W-1:0]          prod_reg;
    logic signed [15:0]                   px2_reg;
    logic [gprr_pkg::ROW_PIXELS-1:0]      mask2_reg;
    logic [gprr_pkg::ROW_PIXELS-1:0]      on2_reg;
    logic [gprr_pkg::COLOR_W-1:0]         fg2_reg;
    logic [gprr_pkg::COLOR_W-1:0]         bg2_reg;

    // Third stage: span record.
    logic                                 v3_reg;
    logic                                 v3_next;
    gprr_pkg::span_t                      span_reg;

    logic                                 ready2;
    logic                                 ready3;
    logic                                 row_vis;
    logic [gprr_pkg::ROW_PIXELS-1:0]      mask_c;
    logic [gprr_pkg::ROW_PIXELS-1:0]      on_c;

    assign ready3   = !v3_reg || down_ready;
    assign ready2   = !v2_reg || ready3;
    assign up_ready = ready2;

    assign row_vis = !up_data.y[16] && ({1'b0, up_data.y[15:0]} < 17'(height));

    always_comb
    begin
        logic [16:0] x;
        logic        x_ok;
        mask_c = '0;
        on_c   = '0;
        for (int c = 0; c < gprr_pkg::ROW_PIXELS; c++)
        begin
            x         = {up_data.px[15], up_data.px} + 17'(c);
            x_ok      = !x[16] && ({1'b0, x[15:0]} < 17'(width));
            on_c[c]   = up_data.bits[gprr_pkg::ROW_PIXELS - 1 - c];
            mask_c[c] = (on_c[c] || up_data.opaque) && x_ok && row_vis;
        end
    end

    assign v2_next = ready2 ? up_valid : v2_reg;
    assign v3_next = ready3 ? v2_reg : v3_reg;

    always_ff @(posedge clk)
    begin
        if (ready2 && up_valid)
        begin
            prod_reg  <= gprr_pkg::PROD_W'(up_data.y[gprr_pkg::COORD_W-1:0])
                       * gprr_pkg::PROD_W'(pitch);
            px2_reg   <= up_data.px;
            mask2_reg <= mask_c;
            on2_reg   <= on_c;
            fg2_reg   <= up_data.fg;
            bg2_reg   <= up_data.bg;
        end
        if (ready3 && v2_reg)
        begin
            span_reg.base <= gprr_pkg::OFFSET_W'(prod_reg) + gprr_pkg::OFFSET_W'(px2_reg);
            span_reg.mask <= mask2_reg;
            span_reg.on   <= on2_reg;
            span_reg.fg   <= fg2_reg;
            span_reg.bg   <= bg2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign s3_valid = v3_reg;
    assign s3_data  = span_reg;

endmodule

@@ rtl/gprr_serializer.sv @@
// Expansion stage: one pixel write per cycle from a span unless stalled, plus output register.
module gprr_serializer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    input  gprr_pkg::span_t               up_data,
    output logic                          up_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [23:0]                   pixel_offset,
    output logic [31:0]                   pixel_value,
    output logic                          last_write
);

    logic                                 ser_valid_reg;
    logic                                 ser_valid_next;
    gprr_pkg::span_t                      ser_reg;
    logic [gprr_pkg::ROW_PIXELS-1:0]      mask_next;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [gprr_pkg::OFFSET_W-1:0]        offset_reg;
    logic [gprr_pkg::COLOR_W-1:0]         value_reg;
    logic                                 last_reg;

    logic                                 out_free;
    logic [gprr_pkg::COL_W-1:0]           sel;
    logic [gprr_pkg::ROW_PIXELS-1:0]      rest;
    logic                                 emit;
    logic                                 done;

    // Leftmost remaining column goes first.
    always_comb
    begin
        logic found;
        found = 1'b0;
        sel   = '0;
        for (int c = 0; c < gprr_pkg::ROW_PIXELS; c++)
        begin
            if (ser_reg.mask[c] && !found)
            begin
                sel   = gprr_pkg::COL_W'(c);
                found = 1'b1;
            end
        end
    end

    assign rest     = ser_reg.mask & ~(gprr_pkg::ROW_PIXELS'(1) << sel);
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = ser_valid_reg && (ser_reg.mask != '0) && out_free;
    assign done     = (ser_reg.mask == '0) || (emit && (rest == '0));
    assign up_ready = !ser_valid_reg || done;

    assign ser_valid_next = up_ready ? up_valid : ser_valid_reg;
    assign mask_next      = emit ? rest : ser_reg.mask;
    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ser_reg <= up_data;
        end
        else
        begin
            ser_reg.mask <= mask_next;
        end
        if (emit)
        begin
            offset_reg <= ser_reg.base + gprr_pkg::OFFSET_W'(sel);
            value_reg  <= ser_reg.on[sel] ? ser_reg.fg : ser_reg.bg;
            last_reg   <= (rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_offset = offset_reg;
    assign pixel_value  = value_reg;
    assign last_write   = last_reg;

endmodule

@@ tb/glyph_row_pixel_renderer_unit_tb.sv @@
// Self-checking testbench for the glyph row pixel renderer top level.
module glyph_row_pixel_renderer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gprr_pkg::*;

    // The whole run is bounded by this many clock cycles; a correct run needs far fewer.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles allowed after the last expected write so that trailing loads finish and empty
    // draws leave the five-stage pipeline before the registers change.
    localparam int SETTLE_CYCLES = 12;

    // One input transaction as the block sees it.
    typedef struct {
        logic               op;
        logic [7:0]         code;
        logic [3:0]         row;
        logic [7:0]         bits;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        fg;
        logic [31:0]        bg;
        logic               opq;
    } glyph_item_t;

    // One framebuffer write as the block should emit it.
    typedef struct {
        logic [23:0] offset;
        logic [31:0] value;
        logic        last;
    } pixel_write_t;

    // The board keeps its own glyph store and screen registers, expands every accepted
    // draw into the pixel writes it must cause, and matches the block's writes in order.
    class pixel_write_board;
        logic [7:0]   glyph_store [STORE_DEPTH];
        int           cfg_width;
        int           cfg_height;
        int           cfg_pitch;
        pixel_write_t pending_writes [$];
        int           mismatches;

        function new();
            cfg_width  = 0;
            cfg_height = 0;
            cfg_pitch  = 0;
            mismatches = 0;
            foreach (glyph_store[i])
                glyph_store[i] = 8'h00;
        endfunction

        function void set_register(logic [1:0] idx, logic [12:0] val);
            case (idx)
                REG_SCREEN_WIDTH:  cfg_width  = int'(val);
                REG_SCREEN_HEIGHT: cfg_height = int'(val);
                REG_ROW_PITCH:     cfg_pitch  = int'(val);
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction

        // Record one accepted transaction: loads update the store, draws queue their writes.
        function void note_transaction(glyph_item_t it);
            logic [7:0]   drawn;
            logic [7:0]   row_bits;
            logic         lit;
            int           w;
            int           h;
            int           p;
            int           y;
            int           x;
            pixel_write_t wr;
            pixel_write_t batch [$];

            if (it.op == OP_LOAD) begin
                if (it.code >= FIRST_CODE && it.code <= LAST_CODE)
                    glyph_store[(int'(it.code) - int'(FIRST_CODE)) * GLYPH_ROWS + int'(it.row)]
                        = it.bits;
                return;
            end

            // Codes outside the printable range are drawn with the question mark glyph.
            drawn = (it.code >= FIRST_CODE && it.code <= LAST_CODE) ? it.code : SUBST_CODE;
            row_bits = glyph_store[(int'(drawn) - int'(FIRST_CODE)) * GLYPH_ROWS + int'(it.row)];

            // Register values above the largest dimension act as that dimension.
            w = (cfg_width  > MAX_DIM) ? MAX_DIM : cfg_width;
            h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
            p = (cfg_pitch  > MAX_DIM) ? MAX_DIM : cfg_pitch;

            y = int'(it.pos_y) + int'(it.row);
            if (y < 0 || y >= h)
                return;

            for (int col = 0; col < 8; col++) begin
                lit = row_bits[7 - col];
                x = int'(it.pos_x) + col;
                if (!lit && !it.opq)
                    continue;
                if (x < 0 || x >= w)
                    continue;
                wr.offset = 24'(y * p + x);
                wr.value  = lit ? it.fg : it.bg;
                wr.last   = 1'b0;
                batch.push_back(wr);
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                pending_writes.push_back(batch[i]);
        endfunction

        // Compare one accepted result with the oldest expected write.
        function void check_pixel_write(logic [23:0] off, logic [31:0] val, logic lw);
            pixel_write_t want;
            if (pending_writes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel write, offset %h value %h last %b",
                         $time, off, val, lw);
                return;
            end
            want = pending_writes.pop_front();
            if (off !== want.offset) begin
                mismatches++;
                $display("%0t: pixel_offset expected %h actual %h", $time, want.offset, off);
            end
            if (val !== want.value) begin
                mismatches++;
                $display("%0t: pixel_value expected %h actual %h", $time, want.value, val);
            end
            if (lw !== want.last) begin
                mismatches++;
                $display("%0t: last_write expected %b actual %b", $time, want.last, lw);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [12:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [7:0]         char_code;
    logic [3:0]         glyph_row;
    logic [7:0]         glyph_bits;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        fg_color;
    logic [31:0]        bg_color;
    logic               opaque;
    logic               out_valid;
    logic               out_stall;
    logic [23:0]        pixel_offset;
    logic [31:0]        pixel_value;
    logic               last_write;

    pixel_write_board board;
    int               cycle_count = 0;
    // Set for the closing stretch of the run, where neither side idles.
    bit               quiet = 1'b0;
    // Effective screen size of the current phase, used to aim positions at the screen.
    int               aim_width = 0;
    int               aim_height = 0;
    // Glyph rows already loaded; a draw is only ever aimed at one of these.
    bit               row_loaded [STORE_DEPTH];

    glyph_row_pixel_renderer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .char_code    (char_code),
        .glyph_row    (glyph_row),
        .glyph_bits   (glyph_bits),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .fg_color     (fg_color),
        .bg_color     (bg_color),
        .opaque       (opaque),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_offset (pixel_offset),
        .pixel_value  (pixel_value),
        .last_write   (last_write)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost write ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d writes still expected",
                     cycle_count, board.outstanding());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Inputs only change at rising edges, so the values seen at the falling edge are the
    // ones the next rising edge samples. A result transaction completes at that edge.
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_pixel_write(pixel_offset, pixel_value, last_write);
    end

    // Receiver stalls: random bursts separated by stall-free stretches, outside the closing stretch.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 30)) @(posedge clk);
            end
        end
    end

    function automatic glyph_item_t make_item(logic o, logic [7:0] c, logic [3:0] r,
                                              logic [7:0] b, int x, int y, logic opq);
        glyph_item_t it;
        it.op    = o;
        it.code  = c;
        it.row   = r;
        it.bits  = b;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.fg    = $urandom;
        it.bg    = $urandom;
        it.opq   = opq;
        return it;
    endfunction

    // Random transaction. Most positions land on or near the screen so that clipping at
    // every edge is exercised; the rest use the full signed range. A draw whose glyph row
    // has never been loaded is turned into a load of that row instead.
    function automatic glyph_item_t random_item();
        glyph_item_t it;
        logic [7:0]  drawn;
        it = make_item(($urandom_range(0, 9) < 7) ? OP_DRAW : OP_LOAD,
                       ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126)) : 8'($urandom),
                       4'($urandom), 8'($urandom), 0, 0, 1'($urandom));
        if ($urandom_range(0, 4) == 0) begin
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
        end
        else begin
            it.pos_x = 16'(int'($urandom_range(0, aim_width + 12)) - 10);
            it.pos_y = 16'(int'($urandom_range(0, aim_height + 5)) - 3 - int'(it.row));
        end
        if (it.op == OP_DRAW) begin
            drawn = (it.code >= FIRST_CODE && it.code <= LAST_CODE) ? it.code : SUBST_CODE;
            if (!row_loaded[(int'(drawn) - int'(FIRST_CODE)) * GLYPH_ROWS + int'(it.row)]) begin
                it.op   = OP_LOAD;
                it.code = drawn;
            end
        end
        return it;
    endfunction

    // Offer one transaction, with an optional idle gap first, and hold it until accepted.
    // Called and returning at a rising edge; valid stays high between back-to-back items.
    task automatic send_item(glyph_item_t it);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        if (it.op == OP_LOAD && it.code >= FIRST_CODE && it.code <= LAST_CODE)
            row_loaded[(int'(it.code) - int'(FIRST_CODE)) * GLYPH_ROWS + int'(it.row)] = 1'b1;
        in_valid   <= 1'b1;
        op         <= it.op;
        char_code  <= it.code;
        glyph_row  <= it.row;
        glyph_bits <= it.bits;
        pos_x      <= it.pos_x;
        pos_y      <= it.pos_y;
        fg_color   <= it.fg;
        bg_color   <= it.bg;
        opaque     <= it.opq;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        board.note_transaction(it);
    endtask

    // Write all three screen registers; only called while the block is idle.
    task automatic configure_screen(int w, int h, int p);
        logic [1:0]  idx [3];
        logic [12:0] val [3];
        idx = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_ROW_PITCH};
        val = '{13'(w), 13'(h), 13'(p)};
        for (int i = 0; i < 3; i++) begin
            cfg_write_en <= 1'b1;
            cfg_index    <= idx[i];
            cfg_wdata    <= val[i];
            @(posedge clk);
            board.set_register(idx[i], val[i]);
        end
        cfg_write_en <= 1'b0;
        aim_width  = (w > MAX_DIM) ? MAX_DIM : w;
        aim_height = (h > MAX_DIM) ? MAX_DIM : h;
        @(posedge clk);
    endtask

    // Stop offering input, wait for every expected write, then let the pipeline empty.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Loads with a non-printable code are ignored by the block and do not count.
    task automatic run_random_phase(int items);
        glyph_item_t it;
        int          sent;
        sent = 0;
        while (sent < items) begin
            it = random_item();
            send_item(it);
            if (!(it.op == OP_LOAD && (it.code < FIRST_CODE || it.code > LAST_CODE)))
                sent++;
        end
        finish_phase();
    endtask

    initial begin
        board = new();
        foreach (row_loaded[i])
            row_loaded[i] = 1'b0;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_SCREEN_WIDTH;
        cfg_wdata    <= '0;
        in_valid     <= 1'b0;
        op           <= OP_LOAD;
        char_code    <= '0;
        glyph_row    <= '0;
        glyph_bits   <= '0;
        pos_x        <= '0;
        pos_y        <= '0;
        fg_color     <= '0;
        bg_color     <= '0;
        opaque       <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a 64 by 32 screen with a wider pitch.
        configure_screen(64, 32, 100);
        send_item(make_item(OP_LOAD, SUBST_CODE, 4'd0, 8'hA5, 0, 0, 1'b0));
        send_item(make_item(OP_LOAD, SUBST_CODE, 4'd15, 8'hFF, 0, 0, 1'b0));
        send_item(make_item(OP_LOAD, 8'd65, 4'd3, 8'h81, 0, 0, 1'b0));
        send_item(make_item(OP_LOAD, FIRST_CODE, 4'd0, 8'h00, 0, 0, 1'b1));
        send_item(make_item(OP_LOAD, LAST_CODE, 4'd7, 8'h5A, 0, 0, 1'b0));
        // Loads of codes outside the printable range must leave the store untouched.
        send_item(make_item(OP_LOAD, 8'd31, 4'd0, 8'hFF, 0, 0, 1'b0));
        send_item(make_item(OP_LOAD, 8'd127, 4'd15, 8'h00, 0, 0, 1'b0));
        send_item(make_item(OP_LOAD, 8'd255, 4'd4, 8'hFF, 0, 0, 1'b1));
        // Opaque and transparent draws at the origin and inside the screen.
        send_item(make_item(OP_DRAW, SUBST_CODE, 4'd0, 8'($urandom), 0, 0, 1'b1));
        send_item(make_item(OP_DRAW, SUBST_CODE, 4'd0, 8'($urandom), 10, 5, 1'b0));
        // Non-printable codes are drawn as the question mark.
        send_item(make_item(OP_DRAW, 8'd0, 4'd0, 8'($urandom), 20, 6, 1'b1));
        send_item(make_item(OP_DRAW, 8'd255, 4'd15, 8'($urandom), 60, 10, 1'b0));
        // Left edge clipping.
        send_item(make_item(OP_DRAW, 8'd65, 4'd3, 8'($urandom), -4, 2, 1'b0));
        // An empty row draws nothing when transparent and only background when opaque.
        send_item(make_item(OP_DRAW, FIRST_CODE, 4'd0, 8'($urandom), 5, 5, 1'b0));
        send_item(make_item(OP_DRAW, FIRST_CODE, 4'd0, 8'($urandom), 5, 5, 1'b1));
        // Bottom edge: one row past the screen, then the last visible row.
        send_item(make_item(OP_DRAW, LAST_CODE, 4'd7, 8'($urandom), 30, 25, 1'b1));
        send_item(make_item(OP_DRAW, LAST_CODE, 4'd7, 8'($urandom), 30, 24, 1'b1));
        // Extreme signed positions.
        send_item(make_item(OP_DRAW, SUBST_CODE, 4'd0, 8'($urandom), -32768, -32768, 1'b1));
        send_item(make_item(OP_DRAW, SUBST_CODE, 4'd0, 8'($urandom), 32767, 32767, 1'b1));
        // A negative glyph top whose bottom row lands on screen row zero.
        send_item(make_item(OP_DRAW, SUBST_CODE, 4'd15, 8'($urandom), 56, -15, 1'b1));
        send_item(make_item(OP_DRAW, 8'd127, 4'd0, 8'($urandom), -1, 31, 1'b1));
        send_item(make_item(OP_DRAW, 8'd31, 4'd15, 8'($urandom), 63, 16, 1'b0));
        finish_phase();

        // Random phases over several screen settings, the extremes among them.
        configure_screen(0, 0, 0);
        run_random_phase(20);
        configure_screen(8191, 8191, 8191);
        run_random_phase(50);
        configure_screen(4096, 4096, 4096);
        run_random_phase(50);
        configure_screen(200, 100, 13);
        run_random_phase(60);
        configure_screen($urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 8191));
        run_random_phase(50);
        configure_screen($urandom_range(0, 300), $urandom_range(0, 200),
                         $urandom_range(0, 8191));
        run_random_phase(50);

        // Closing stretch with both sides running flat out.
        quiet = 1'b1;
        configure_screen(640, 480, 640);
        run_random_phase(70);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gprr_pkg.sv
rtl/gprr_glyph_fetch.sv
rtl/gprr_clip.sv
rtl/gprr_serializer.sv
rtl/glyph_row_pixel_renderer_unit.sv
tb/glyph_row_pixel_renderer_unit_tb.sv
